/* rtl/gwe_pkg.sv */
// Shared types and constants for the graph walk engine.
// Used by gwe_ctrl, gwe_dp and graph_walk_engine; depends on nothing.
package gwe_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_DEGREE_DEF   = 16;

  localparam int VTX_W  = 6;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;
  localparam int VCNT_W = 7;

  localparam logic [VCNT_W-1:0] VCNT_RESET = 7'd64;

  // configuration register indexes
  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_WALK_ORDER   = 1'b1;

  typedef logic [VTX_W-1:0] gwe_vtx_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_EDGE  = 2'd0,
    KIND_WALK  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NONE  = 2'd3
  } gwe_kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } gwe_status_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    gwe_vtx_t          first_vertex;
    gwe_vtx_t          second_vertex;
  } gwe_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    gwe_vtx_t          vertex;
    logic              last;
  } gwe_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_E_CHK, S_E_W2, S_RESP,
    S_B_POP, S_B_VTX, S_B_CNT, S_B_EMIT, S_B_SCAN, S_B_CHK,
    S_D_TOP, S_D_V, S_D_RD, S_D_CMP, S_D_CHK, S_D_W,
    S_FIN
  } gwe_state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_EDGE_W1, OP_EDGE_W2, OP_CLEAR,
    OP_BFS_INIT, OP_DFS_INIT, OP_POP_HEAD, OP_LOAD_V, OP_BFS_EMIT,
    OP_SCAN, OP_BFS_CHK, OP_DFS_ADV, OP_DFS_POP, OP_LATCH_W, OP_DFS_PUSH
  } gwe_op_t;

  typedef enum logic [1:0] {
    RSP_STATUS, RSP_VTX, RSP_VTX_LAST
  } gwe_rsp_sel_t;

  typedef struct packed {
    gwe_op_t      op;
    logic         rsp_load;
    gwe_rsp_sel_t rsp_sel;
    gwe_status_t  status;
    logic         cnt_cur;   // count port A reads current vertex
    logic         wl_top;    // work list read at top of stack
    logic         nbr_dfs;   // store read offset from resume position
  } gwe_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              a_oor;
    logic              b_oor;
    logic              full;
    logic              walk_dfs;
    logic              head_lt_tail;
    logic              tail_zero;
    logic              idx_lt_deg;
    logic              nn_lt_cnt;
    logic              dfs_ok;
    logic              pend_vld;
    logic              rsp_free;
  } gwe_stat_t;

endpackage

/* rtl/gwe_ctrl.sv */
// Sequencer for the graph walk engine: edge insert, clear and walk steps.
// Depends on gwe_pkg; drives gwe_dp through gwe_cmd_t.
module gwe_ctrl import gwe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output gwe_cmd_t  cmd,
  input  gwe_stat_t stat
);

  gwe_state_t  state, state_next;
  gwe_status_t resp_st, resp_st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      resp_st <= ST_OK;
    end else begin
      state   <= state_next;
      resp_st <= resp_st_next;
    end
  end

  always_comb begin
    state_next   = state;
    resp_st_next = resp_st;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (gwe_kind_t'(stat.kind))
          KIND_EDGE: begin
            if (stat.a_oor || stat.b_oor) begin
              state_next   = S_RESP;
              resp_st_next = ST_RANGE;
            end else begin
              state_next = S_E_CHK;
            end
          end
          KIND_WALK: begin
            if (stat.a_oor) begin
              state_next   = S_RESP;
              resp_st_next = ST_RANGE;
            end else begin
              state_next = stat.walk_dfs ? S_D_TOP : S_B_POP;
            end
          end
          default: begin
            state_next   = S_RESP;
            resp_st_next = ST_OK;
          end
        endcase
      end
      S_E_CHK: begin
        if (stat.full) begin
          state_next   = S_RESP;
          resp_st_next = ST_FULL;
        end else begin
          state_next = S_E_W2;
        end
      end
      S_E_W2: begin
        state_next   = S_RESP;
        resp_st_next = ST_OK;
      end
      S_RESP: begin
        if (stat.rsp_free) state_next = S_IDLE;
      end
      S_B_POP:  state_next = stat.head_lt_tail ? S_B_VTX : S_FIN;
      S_B_VTX:  state_next = S_B_CNT;
      S_B_CNT:  state_next = S_B_EMIT;
      S_B_EMIT: begin
        if (!stat.pend_vld || stat.rsp_free) state_next = S_B_SCAN;
      end
      S_B_SCAN: state_next = stat.idx_lt_deg ? S_B_CHK : S_B_POP;
      S_B_CHK:  state_next = S_B_SCAN;
      S_D_TOP:  state_next = stat.tail_zero ? S_FIN : S_D_V;
      S_D_V:    state_next = S_D_RD;
      S_D_RD:   state_next = S_D_CMP;
      S_D_CMP:  state_next = stat.nn_lt_cnt ? S_D_CHK : S_D_TOP;
      S_D_CHK:  state_next = S_D_W;
      S_D_W: begin
        if (!stat.dfs_ok || stat.rsp_free) state_next = S_D_TOP;
      end
      S_FIN: begin
        if (stat.rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready    = 1'b0;
    cmd.op       = OP_NONE;
    cmd.rsp_load = 1'b0;
    cmd.rsp_sel  = RSP_STATUS;
    cmd.status   = ST_OK;
    cmd.cnt_cur  = 1'b0;
    cmd.wl_top   = 1'b0;
    cmd.nbr_dfs  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) cmd.op = OP_LATCH;
      end
      S_DECODE: begin
        unique case (gwe_kind_t'(stat.kind))
          KIND_WALK: begin
            if (!stat.a_oor) cmd.op = stat.walk_dfs ? OP_DFS_INIT : OP_BFS_INIT;
          end
          KIND_CLEAR: cmd.op = OP_CLEAR;
          default:    cmd.op = OP_NONE;
        endcase
      end
      S_E_CHK: begin
        if (!stat.full) cmd.op = OP_EDGE_W1;
      end
      S_E_W2: cmd.op = OP_EDGE_W2;
      S_RESP: begin
        cmd.rsp_load = stat.rsp_free;
        cmd.rsp_sel  = RSP_STATUS;
        cmd.status   = resp_st;
      end
      S_B_POP: begin
        if (stat.head_lt_tail) cmd.op = OP_POP_HEAD;
      end
      S_B_VTX: cmd.op = OP_LOAD_V;
      S_B_CNT: cmd.cnt_cur = 1'b1;
      S_B_EMIT: begin
        cmd.cnt_cur = 1'b1;
        if (!stat.pend_vld || stat.rsp_free) begin
          cmd.op       = OP_BFS_EMIT;
          cmd.rsp_load = stat.pend_vld;
          cmd.rsp_sel  = RSP_VTX;
        end
      end
      S_B_SCAN: begin
        if (stat.idx_lt_deg) cmd.op = OP_SCAN;
      end
      S_B_CHK: cmd.op = OP_BFS_CHK;
      S_D_TOP: cmd.wl_top = 1'b1;
      S_D_V:   cmd.op = OP_LOAD_V;
      S_D_RD:  cmd.cnt_cur = 1'b1;
      S_D_CMP: begin
        cmd.cnt_cur = 1'b1;
        cmd.nbr_dfs = 1'b1;
        cmd.op      = stat.nn_lt_cnt ? OP_DFS_ADV : OP_DFS_POP;
      end
      S_D_CHK: cmd.op = OP_LATCH_W;
      S_D_W: begin
        if (stat.dfs_ok && stat.rsp_free) begin
          cmd.op       = OP_DFS_PUSH;
          cmd.rsp_load = 1'b1;
          cmd.rsp_sel  = RSP_VTX;
        end
      end
      S_FIN: begin
        cmd.rsp_load = stat.rsp_free;
        cmd.rsp_sel  = RSP_VTX_LAST;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

/* rtl/gwe_dp.sv */
// Datapath of the graph walk engine: neighbor lists, counts, work list,
// visited marks, config registers and the result register. Uses gwe_pkg.
module gwe_dp import gwe_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  gwe_req_t          req,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [VCNT_W-1:0] cfg_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output gwe_rsp_t          rsp,
  input  gwe_cmd_t          cmd,
  output gwe_stat_t         stat
);

  localparam int VIW = $clog2(MAX_VERTICES);
  localparam int PW  = $clog2(MAX_VERTICES + 1);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int SD  = MAX_VERTICES * MAX_DEGREE;
  localparam int SAW = $clog2(SD);
  localparam logic [VCNT_W-1:0] NV_MAX  = VCNT_W'(MAX_VERTICES);
  localparam logic [CW-1:0]     CNT_MAX = CW'(MAX_DEGREE);
  localparam logic [PW-1:0]     PTR_MAX = PW'(MAX_VERTICES);

  function automatic logic [SAW-1:0] st_addr(input logic [VIW-1:0] v,
                                             input logic [CW-1:0] i);
    st_addr = SAW'(int'(v) * MAX_DEGREE + int'(i));
  endfunction

  logic [VCNT_W-1:0]   vertex_count;
  logic                walk_order;
  logic [KIND_W-1:0]   kind_q;
  gwe_vtx_t            a_q, b_q, cur_v, w_reg, pend;
  logic                pend_vld;
  logic [PW-1:0]       head, tail;
  logic [CW-1:0]       idx, deg;
  logic [MAX_VERTICES-1:0] visited, cnt_vld;

  logic [CW-1:0]    cnt_mem [MAX_VERTICES];
  logic [VTX_W-1:0] nbr_mem [SD];
  logic [VTX_W-1:0] wl_mem  [MAX_VERTICES];
  logic [CW-1:0]    nn_mem  [MAX_VERTICES];

  logic [CW-1:0]    cnt_a_q, cnt_b_q, nn_q;
  logic [VTX_W-1:0] nbr_q, wl_q;

  logic [VCNT_W-1:0] nv;
  logic              self_loop, full, bfs_ok, dfs_ok, rsp_free;
  logic [CW:0]       cnt_a_p2;
  logic [CW-1:0]     cnt_b_eff;
  logic [VIW-1:0]    cnt_ra, cnt_rb, cnt_wa, wl_ra;
  logic [CW-1:0]     cnt_wd;
  logic              cnt_we;
  logic [SAW-1:0]    nbr_ra;
  logic [PW-1:0]     tail_m1;
  logic [MAX_VERTICES-1:0] start_mark;

  assign nv        = (vertex_count > NV_MAX) ? NV_MAX : vertex_count;
  assign self_loop = (a_q == b_q);
  assign cnt_a_p2  = {1'b0, cnt_a_q} + (CW+1)'(2);
  // a self-loop takes two slots of the same list
  assign full      = self_loop ? (cnt_a_p2 > (CW+1)'(MAX_DEGREE))
                               : (cnt_a_q >= CNT_MAX || cnt_b_q >= CNT_MAX);
  assign cnt_b_eff = self_loop ? CW'(cnt_a_q + 1'b1) : cnt_b_q;

  assign bfs_ok = (VCNT_W'(nbr_q) < nv) && !visited[nbr_q[VIW-1:0]] && (tail < PTR_MAX);
  assign dfs_ok = (VCNT_W'(w_reg) < nv) && !visited[w_reg[VIW-1:0]] && (tail < PTR_MAX);
  assign rsp_free = !rsp_valid || rsp_ready;

  assign cnt_ra  = cmd.cnt_cur ? cur_v[VIW-1:0] : a_q[VIW-1:0];
  assign cnt_rb  = b_q[VIW-1:0];
  assign cnt_we  = (cmd.op == OP_EDGE_W1) || (cmd.op == OP_EDGE_W2);
  assign cnt_wa  = (cmd.op == OP_EDGE_W1) ? a_q[VIW-1:0] : b_q[VIW-1:0];
  assign cnt_wd  = (cmd.op == OP_EDGE_W1) ? CW'(cnt_a_q + 1'b1) : CW'(cnt_b_eff + 1'b1);
  assign tail_m1 = tail - 1'b1;
  assign wl_ra   = cmd.wl_top ? tail_m1[VIW-1:0] : head[VIW-1:0];
  assign nbr_ra  = st_addr(cur_v[VIW-1:0], cmd.nbr_dfs ? nn_q : idx);
  assign start_mark = MAX_VERTICES'(1) << a_q[VIW-1:0];

  // neighbor counts: memory plus per-entry valid bits
  always_ff @(posedge clk) begin
    cnt_a_q <= cnt_vld[cnt_ra] ? cnt_mem[cnt_ra] : '0;
    cnt_b_q <= cnt_vld[cnt_rb] ? cnt_mem[cnt_rb] : '0;
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_CLEAR) begin
      cnt_vld <= '0;
    end else if (cnt_we) begin
      cnt_vld[cnt_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    nbr_q <= nbr_mem[nbr_ra];
    if (cmd.op == OP_EDGE_W1) nbr_mem[st_addr(a_q[VIW-1:0], cnt_a_q)] <= b_q;
    else if (cmd.op == OP_EDGE_W2) nbr_mem[st_addr(b_q[VIW-1:0], cnt_b_eff)] <= a_q;
  end

  always_ff @(posedge clk) begin
    wl_q <= wl_mem[wl_ra];
    if (cmd.op == OP_BFS_INIT || cmd.op == OP_DFS_INIT) wl_mem[0] <= a_q;
    else if (cmd.op == OP_BFS_CHK && bfs_ok) wl_mem[tail[VIW-1:0]] <= nbr_q;
    else if (cmd.op == OP_DFS_PUSH) wl_mem[tail[VIW-1:0]] <= w_reg;
  end

  always_ff @(posedge clk) begin
    nn_q <= nn_mem[cur_v[VIW-1:0]];
    if (cmd.op == OP_DFS_INIT) nn_mem[a_q[VIW-1:0]] <= '0;
    else if (cmd.op == OP_DFS_ADV) nn_mem[cur_v[VIW-1:0]] <= CW'(nn_q + 1'b1);
    else if (cmd.op == OP_DFS_PUSH) nn_mem[w_reg[VIW-1:0]] <= '0;
  end

  // walk control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      pend_vld <= 1'b0;
      visited  <= '0;
    end else begin
      unique case (cmd.op)
        OP_LATCH:    pend_vld <= 1'b0;
        OP_BFS_INIT: begin
          visited <= start_mark;
          head    <= '0;
          tail    <= PW'(1);
        end
        OP_DFS_INIT: begin
          visited  <= start_mark;
          head     <= '0;
          tail     <= PW'(1);
          pend_vld <= 1'b1;
        end
        OP_POP_HEAD: head <= head + 1'b1;
        OP_BFS_EMIT: pend_vld <= 1'b1;
        OP_BFS_CHK: begin
          if (bfs_ok) begin
            visited[nbr_q[VIW-1:0]] <= 1'b1;
            tail <= tail + 1'b1;
          end
        end
        OP_DFS_POP: tail <= tail_m1;
        OP_DFS_PUSH: begin
          visited[w_reg[VIW-1:0]] <= 1'b1;
          tail <= tail + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH: begin
        kind_q <= req.kind;
        a_q    <= req.first_vertex;
        b_q    <= req.second_vertex;
      end
      OP_DFS_INIT: pend <= a_q;
      OP_LOAD_V: begin
        cur_v <= wl_q;
        idx   <= '0;
      end
      OP_BFS_EMIT: begin
        pend <= cur_v;
        deg  <= cnt_a_q;
      end
      OP_SCAN:     idx   <= idx + 1'b1;
      OP_LATCH_W:  w_reg <= nbr_q;
      OP_DFS_PUSH: pend  <= w_reg;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCNT_RESET;
      walk_order   <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERTEX_COUNT: vertex_count <= cfg_data;
        REG_WALK_ORDER:   walk_order   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      unique case (cmd.rsp_sel)
        RSP_STATUS:   rsp <= '{status: cmd.status, vertex: '0, last: 1'b1};
        RSP_VTX:      rsp <= '{status: ST_OK, vertex: pend, last: 1'b0};
        RSP_VTX_LAST: rsp <= '{status: ST_OK, vertex: pend, last: 1'b1};
        default:      rsp <= '{status: ST_OK, vertex: '0, last: 1'b1};
      endcase
    end
  end

  assign stat.kind         = kind_q;
  assign stat.a_oor        = VCNT_W'(a_q) >= nv;
  assign stat.b_oor        = VCNT_W'(b_q) >= nv;
  assign stat.full         = full;
  assign stat.walk_dfs     = walk_order;
  assign stat.head_lt_tail = head < tail;
  assign stat.tail_zero    = (tail == '0);
  assign stat.idx_lt_deg   = idx < deg;
  assign stat.nn_lt_cnt    = nn_q < cnt_a_q;
  assign stat.dfs_ok       = dfs_ok;
  assign stat.pend_vld     = pend_vld;
  assign stat.rsp_free     = rsp_free;

`ifndef SYNTHESIS
  a_tail_bound: assert property (@(posedge clk) disable iff (rst) tail <= PTR_MAX)
    else $error("work list pointer past capacity");
  a_head_le_tail: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("queue head passed tail");
  a_start_mark: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_BFS_INIT |=> $onehot(visited))
    else $error("walk start must leave exactly one visited mark");
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt_we |-> cnt_wd <= CNT_MAX)
    else $error("neighbor count written beyond list size");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst) cmd.rsp_load |-> rsp_free)
    else $error("result beat overwritten before it was taken");
`endif

endmodule

/* rtl/graph_walk_engine.sv */
// Top level of the graph walk engine: sequencer plus datapath.
// Depends on gwe_pkg, gwe_ctrl and gwe_dp.
//
//  port group   dir  handshake              payload
//  req          in   req_valid/req_ready    gwe_req_t (kind, first/second vertex)
//  rsp          out  rsp_valid/rsp_ready    gwe_rsp_t (status, vertex, last)
//  cfg          in   cfg_write              cfg_index, cfg_data
//
// One item at a time. Edge insert checks range and fullness, then writes both
// lists; clear resets the count valid bits. BFS pops a vertex, reads its count,
// emits it and checks each list entry; DFS reads the stack top, pushes or pops.
// Synchronous reset; count valid bits clear at once, so no clearing pass.
// A full result register stalls the walk at its next result beat.
module graph_walk_engine import gwe_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_DEGREE   = MAX_DEGREE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  gwe_req_t          req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output gwe_rsp_t          rsp,
  input  logic              cfg_write,
  input  logic              cfg_index,
  input  logic [VCNT_W-1:0] cfg_data
);

  gwe_cmd_t  cmd;
  gwe_stat_t stat;

  gwe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  gwe_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* bench/graph_walk_engine_test.sv */
// Self-checking bench for graph_walk_engine: edge inserts, clears and BFS/DFS walks.
// Depends on gwe_pkg and the graph_walk_engine RTL.
`timescale 1ns / 100ps

module graph_walk_engine_test;
  import gwe_pkg::*;

  localparam int NV = 64;
  localparam int DEG = 16;
  localparam longint CYCLE_LIMIT = 20000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  gwe_req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  gwe_rsp_t rsp;
  logic cfg_write = 1'b0;
  logic cfg_index = REG_VERTEX_COUNT;
  logic [VCNT_W-1:0] cfg_data = '0;

  graph_walk_engine dut (.*);

  // graph mirror
  int unsigned live_vertices;
  bit depth_first;
  int unsigned degree [NV];
  int unsigned adjacency [NV][DEG];

  gwe_rsp_t pending_rsp [$];
  int unsigned mismatches = 0;
  int unsigned rsp_beats = 0;
  int unsigned walks_done = 0;
  longint cycles = 0;
  int unsigned stall_hold = 0;
  bit rsp_random = 1'b1;

  initial forever #5 clk = ~clk;

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic void push_rsp(gwe_status_t st, int unsigned v, bit lst);
    gwe_rsp_t r;
    r.status = st;
    r.vertex = gwe_vtx_t'(v);
    r.last = lst;
    pending_rsp.insert(pending_rsp.size(), r);
  endfunction

  // computes the result beats an item causes and updates the mirror
  function automatic void predict_item(gwe_req_t it);
    int unsigned a, b, n, v, w, top;
    bit seen [NV];
    int unsigned order [$];
    int unsigned stk [$];
    int unsigned resume [NV];
    a = it.first_vertex;
    b = it.second_vertex;
    n = live_vertices;
    case (gwe_kind_t'(it.kind))
      KIND_EDGE: begin
        if (a >= n || b >= n) push_rsp(ST_RANGE, 0, 1);
        else if ((a == b && degree[a] + 2 > DEG) ||
                 (a != b && (degree[a] >= DEG || degree[b] >= DEG)))
          push_rsp(ST_FULL, 0, 1);
        else begin
          adjacency[a][degree[a]] = b;
          degree[a]++;
          adjacency[b][degree[b]] = a;
          degree[b]++;
          push_rsp(ST_OK, 0, 1);
        end
      end
      KIND_CLEAR: begin
        foreach (degree[i]) degree[i] = 0;
        push_rsp(ST_OK, 0, 1);
      end
      KIND_NONE: push_rsp(ST_OK, 0, 1);
      default: begin
        if (a >= n) push_rsp(ST_RANGE, 0, 1);
        else begin
          foreach (seen[i]) seen[i] = 0;
          seen[a] = 1;
          if (!depth_first) begin
            stk.insert(stk.size(), a);
            while (stk.size() > 0) begin
              v = stk.pop_front();
              order.insert(order.size(), v);
              for (int i = 0; i < degree[v]; i++) begin
                w = adjacency[v][i];
                if (w < n && !seen[w]) begin
                  seen[w] = 1;
                  stk.insert(stk.size(), w);
                end
              end
            end
          end else begin
            order.insert(order.size(), a);
            resume[a] = 0;
            stk.insert(stk.size(), a);
            while (stk.size() > 0) begin
              top = stk[stk.size()-1];
              if (resume[top] < degree[top]) begin
                w = adjacency[top][resume[top]];
                resume[top]++;
                if (w < n && !seen[w]) begin
                  seen[w] = 1;
                  order.insert(order.size(), w);
                  resume[w] = 0;
                  stk.insert(stk.size(), w);
                end
              end else void'(stk.pop_back());
            end
          end
          foreach (order[i]) push_rsp(ST_OK, order[i], i == order.size() - 1);
          walks_done++;
        end
      end
    endcase
  endfunction

  // response side: random stalls, or a long hold when requested
  initial begin
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (stall_hold > 0) begin
        rsp_ready <= 1'b0;
        stall_hold--;
      end else if (rsp_random && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(0, 16);
        if (gap > 0) begin
          rsp_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        rsp_ready <= 1'b1;
      end else rsp_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    gwe_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_beats++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected beat: %p", rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.vertex !== want.vertex ||
            rsp.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected st=%0d v=%0d last=%0d, got st=%0d v=%0d last=%0d",
                     want.status, want.vertex, want.last, rsp.status, rsp.vertex, rsp.last);
        end
      end
    end
  end

  bit sender_gaps = 1'b1;

  task automatic send_item(gwe_kind_t k, int unsigned a, int unsigned b);
    int unsigned gap;
    gwe_req_t it;
    if (sender_gaps && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(0, 16);
      repeat (gap) @(posedge clk);
    end
    it.kind = k;
    it.first_vertex = gwe_vtx_t'(a);
    it.second_vertex = gwe_vtx_t'(b);
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    predict_item(it);
    req_valid <= 1'b0;
    // engine is busy right after a beat, so this edge costs nothing
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (pending_rsp.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int unsigned val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= VCNT_W'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == REG_VERTEX_COUNT) live_vertices = (val & 127) > NV ? NV : (val & 127);
    else depth_first = val[0];
  endtask

  task automatic test_directed();
    send_item(KIND_WALK, 0, 0);
    send_item(KIND_EDGE, 0, 63);
    send_item(KIND_EDGE, 63, 5);
    send_item(KIND_EDGE, 5, 5);
    send_item(KIND_EDGE, 0, 1);
    send_item(KIND_EDGE, 1, 2);
    send_item(KIND_NONE, 63, 63);
    send_item(KIND_WALK, 0, 42);
    // fill vertex 7 to trigger a full-list status
    for (int i = 0; i < 8; i++) send_item(KIND_EDGE, 7, 7);
    send_item(KIND_EDGE, 7, 8);
    send_item(KIND_WALK, 7, 0);
    drain_results();
    write_reg(REG_WALK_ORDER, 1);
    send_item(KIND_WALK, 0, 0);
    send_item(KIND_WALK, 63, 0);
    drain_results();
    // stale neighbors above a reduced count are skipped
    write_reg(REG_VERTEX_COUNT, 6);
    send_item(KIND_WALK, 0, 0);
    send_item(KIND_EDGE, 6, 0);
    send_item(KIND_WALK, 6, 0);
    send_item(KIND_CLEAR, 0, 0);
    send_item(KIND_WALK, 0, 0);
    drain_results();
    write_reg(REG_VERTEX_COUNT, 0);
    send_item(KIND_EDGE, 0, 0);
    send_item(KIND_WALK, 0, 0);
    drain_results();
  endtask

  // builds a random graph then walks it a few times
  task automatic run_phase(int unsigned vc, bit dfs, int unsigned edges);
    int unsigned span;
    write_reg(REG_VERTEX_COUNT, vc);
    write_reg(REG_WALK_ORDER, dfs);
    span = live_vertices == 0 ? 1 : live_vertices;
    send_item(KIND_CLEAR, $urandom, $urandom);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_item(gwe_kind_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                  $urandom_range(0, 63));
      else
        send_item(KIND_EDGE, $urandom_range(0, span - 1), $urandom_range(0, span - 1));
      if ($urandom_range(0, 7) == 0) send_item(KIND_WALK, $urandom_range(0, span - 1), $urandom);
    end
    for (int i = 0; i < 3; i++) send_item(KIND_WALK, $urandom_range(0, span - 1), $urandom);
    drain_results();
  endtask

  task automatic test_random();
    run_phase(64, 0, 25);
    run_phase(64, 1, 25);
    run_phase(1, 0, 6);
    run_phase(127, 1, 25);
    run_phase(12, 0, 25);
    run_phase(20, 1, 25);
    run_phase(5, 1, 20);
  endtask

  // response side held off while requests keep coming, then a full drain pause
  task automatic test_backpressure();
    write_reg(REG_VERTEX_COUNT, 64);
    write_reg(REG_WALK_ORDER, 0);
    sender_gaps = 1'b0;
    stall_hold = 300;
    for (int i = 0; i < 10; i++) send_item(KIND_EDGE, i, i + 1);
    send_item(KIND_WALK, 0, 0);
    while (pending_rsp.size() > 0) @(posedge clk);
    sender_gaps = 1'b1;
    send_item(KIND_WALK, 10, 0);
    drain_results();
  endtask

  initial begin
    live_vertices = NV;
    depth_first = 1'b0;
    foreach (degree[i]) degree[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    test_backpressure();
    $display("Checked %0d result beats across %0d walks, BFS and DFS, counts 0 to 127.",
             rsp_beats, walks_done);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d beats missing", mismatches, pending_rsp.size());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
